[rtl/core/adtdn_pkg.sv]
// Shared types, constants and tables for the ASCII date to day number block.
`default_nettype none

package adtdn_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int BYTE_W    = 8;
   localparam int DIGIT_W   = 10;   // byte - '0', signed
   localparam int YEAR_SW   = 20;   // signed weighted year before range check
   localparam int MD_SW     = 14;   // signed weighted month or day
   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int DBM_W     = 9;    // days before month, up to 334
   localparam int QUOT_W    = 7;    // year / 100, up to 99
   localparam int RECIP_W   = 13;
   localparam int DAYNUM_W  = 22;
   localparam int TDATA_IN_W  = 64;
   localparam int TDATA_OUT_W = 24;

   localparam int ASCII_ZERO = 48;
   localparam int YEAR_MIN   = 1900;
   localparam int YEAR_MAX   = 9999;
   localparam int MONTH_MAX  = 12;
   localparam int DAY_MAX    = 31;
   localparam int DAYS_PER_YEAR = 365;

   // floor(x / 100) == (x * 5243) >> 19 for all x below 10000
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   typedef struct packed {
      logic                 ok;
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
   } date_type;

   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [DBM_W-1:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

[rtl/core/adtdn_front.sv]
// Front part: turns eight ASCII bytes into year, month, day and a range verdict.
`default_nettype none

module adtdn_front (
   input  wire logic [adtdn_pkg::TDATA_IN_W-1:0] req_tdata,
   output adtdn_pkg::date_type                   date
);

   logic signed [adtdn_pkg::DIGIT_W-1:0] digit [8];
   logic signed [adtdn_pkg::YEAR_SW-1:0] year_val;
   logic signed [adtdn_pkg::MD_SW-1:0]   month_val;
   logic signed [adtdn_pkg::MD_SW-1:0]   day_val;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digit[i] = $signed({2'b00, req_tdata[i*adtdn_pkg::BYTE_W +: adtdn_pkg::BYTE_W]})
                    - 10'(adtdn_pkg::ASCII_ZERO);
      end
   end

   // no digit check: any byte counts with its weight
   assign year_val  = 20'(digit[0]) * 20'sd1000 + 20'(digit[1]) * 20'sd100
                    + 20'(digit[2]) * 20'sd10   + 20'(digit[3]);
   assign month_val = 14'(digit[4]) * 14'sd10 + 14'(digit[5]);
   assign day_val   = 14'(digit[6]) * 14'sd10 + 14'(digit[7]);

   always_comb begin
      date.ok    = (day_val   >= 14'sd1) && (day_val   <= 14'(adtdn_pkg::DAY_MAX))
                && (month_val >= 14'sd1) && (month_val <= 14'(adtdn_pkg::MONTH_MAX))
                && (year_val  >= 20'(adtdn_pkg::YEAR_MIN))
                && (year_val  <= 20'(adtdn_pkg::YEAR_MAX));
      date.year  = year_val[adtdn_pkg::YEAR_W-1:0];
      date.month = month_val[adtdn_pkg::MONTH_W-1:0];
      date.day   = day_val[adtdn_pkg::DAY_W-1:0];
   end

endmodule

`default_nettype wire

[rtl/core/adtdn_queue.sv]
// Small FIFO of classified dates between the front and back parts.
`default_nettype none

module adtdn_queue #(
   parameter int DEPTH = adtdn_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire adtdn_pkg::date_type push_data,
   output logic                     not_full,
   input  wire logic                pop,
   output logic                     not_empty,
   output adtdn_pkg::date_type      head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   adtdn_pkg::date_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign not_full  = (count_ff != CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/adtdn_back.sv]
// Back part: two-stage day number pipeline with an output register.
`default_nettype none

module adtdn_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  wire adtdn_pkg::date_type               head,
   output logic                                   head_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [adtdn_pkg::DAYNUM_W-1:0]         rsp_day_number
);

   localparam int PROD_W = adtdn_pkg::YEAR_W + adtdn_pkg::RECIP_W;
   localparam int YW     = adtdn_pkg::YEAR_W;
   localparam int QW     = adtdn_pkg::QUOT_W;
   localparam int NW     = adtdn_pkg::DAYNUM_W;

   // stage A: divisions by reciprocal, 365*(y-1), month table
   logic [YW-1:0]     prev;
   logic [PROD_W-1:0] prev_prod, year_prod;

   logic                            a_valid_ff, a_valid_in;
   logic                            a_ok_ff;
   logic [adtdn_pkg::DAY_W-1:0]     a_day_ff;
   logic [adtdn_pkg::DBM_W-1:0]     a_dbm_ff;
   logic                            a_late_ff;     // past February, year divisible by 4
   logic [YW-1:0]                   a_year_ff;
   logic [QW-1:0]                   a_qy_ff;       // year / 100
   logic [QW-1:0]                   a_qp_ff;       // (year-1) / 100
   logic [YW-3:0]                   a_prev_q4_ff;  // (year-1) / 4
   logic [NW-1:0]                   a_p365_ff;

   // stage B: leap fixup and final sum
   logic [YW-1:0] rem100;
   logic          leap_day;
   logic [NW-1:0] total;

   logic          out_valid_ff, out_valid_in;
   logic [NW-1:0] out_day_ff;
   logic          out_free, a_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign a_free    = !a_valid_ff || out_free;
   assign head_pop  = head_valid && a_free;

   assign prev      = head.year - YW'(1);
   assign prev_prod = PROD_W'(prev) * PROD_W'(adtdn_pkg::RECIP_100);
   assign year_prod = PROD_W'(head.year) * PROD_W'(adtdn_pkg::RECIP_100);

   assign rem100   = a_year_ff - YW'(a_qy_ff) * YW'(100);
   assign leap_day = a_late_ff && ((rem100 != '0) || (a_qy_ff[1:0] == 2'b00));
   assign total    = a_p365_ff + NW'(a_prev_q4_ff) - NW'(a_qp_ff) + NW'(a_qp_ff[QW-1:2])
                   + NW'(a_dbm_ff) + NW'(a_day_ff) + NW'(leap_day);

   assign a_valid_in   = head_pop   || (a_valid_ff && !out_free);
   assign out_valid_in = (a_valid_ff && out_free) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         a_ok_ff      <= head.ok;
         a_day_ff     <= head.day;
         a_dbm_ff     <= adtdn_pkg::days_before_month(head.month);
         a_late_ff    <= (head.month > adtdn_pkg::MONTH_W'(2)) && (head.year[1:0] == 2'b00);
         a_year_ff    <= head.year;
         a_qy_ff      <= year_prod[adtdn_pkg::RECIP_SHIFT +: QW];
         a_qp_ff      <= prev_prod[adtdn_pkg::RECIP_SHIFT +: QW];
         a_prev_q4_ff <= prev[YW-1:2];
         a_p365_ff    <= NW'(prev) * NW'(adtdn_pkg::DAYS_PER_YEAR);
      end
      if (a_valid_ff && out_free) begin
         out_day_ff <= a_ok_ff ? total : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_day_number = out_day_ff;

endmodule

`default_nettype wire

[rtl/core/ascii_date_to_day_number.sv]
// Top level of the ASCII date (YYYYMMDD) to Gregorian day number converter.
// Takes one date per item as eight ASCII bytes and returns one day number per
// item: day + days of the preceding months (+1 after February in a leap year)
// + 365*(y-1) + (y-1)/4 - (y-1)/100 + (y-1)/400. Each byte counts as its code
// minus '0' with no digit check. The result is zero unless day is 1..31,
// month is 1..12 and year is 1900..9999; the day is not checked against the
// length of its month, so February 31 lands two or three days into March. The
// block keeps no state between items. Throughput is one item per cycle while
// rsp_tready is high. An accepted date is written into the queue, then loaded
// into the reciprocal divide stage; its final sum then goes into the output
// register. A queue of QUEUE_DEPTH entries between front and back absorbs
// output stalls, and req_tready stays high while the queue has room.
`default_nettype none

module ascii_date_to_day_number #(
   parameter int QUEUE_DEPTH = adtdn_pkg::QUEUE_DEPTH_DEFAULT   // 2..16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item in
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [7:0] year_char_thousands, [15:8] year_char_hundreds,
   // [23:16] year_char_tens, [31:24] year_char_units,
   // [39:32] month_char_tens, [47:40] month_char_units,
   // [55:48] day_char_tens, [63:56] day_char_units
   input  wire logic [adtdn_pkg::TDATA_IN_W-1:0]    req_tdata,
   // item out
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [21:0] day_number, [23:22] zero
   output logic [adtdn_pkg::TDATA_OUT_W-1:0]        rsp_tdata
);

   adtdn_pkg::date_type              front_date;
   adtdn_pkg::date_type              queue_head;
   logic                             queue_not_full;
   logic                             queue_not_empty;
   logic                             queue_pop;
   logic                             req_take;
   logic [adtdn_pkg::DAYNUM_W-1:0]   day_number;

   assign req_tready = queue_not_full;
   assign req_take   = req_tvalid && queue_not_full;

   // parse digits and range-check the date
   adtdn_front u_front (
      .req_tdata (req_tdata),
      .date      (front_date)
   );

   adtdn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_data (front_date),
      .not_full  (queue_not_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // day number arithmetic and output register
   adtdn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (queue_not_empty),
      .head           (queue_head),
      .head_pop       (queue_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_day_number (day_number)
   );

   assign rsp_tdata = {(adtdn_pkg::TDATA_OUT_W - adtdn_pkg::DAYNUM_W)'(0), day_number};

endmodule

`default_nettype wire

[tb/date_day_number_checker.sv]
// Checker for the date converter: predicts each day number and compares it with the block.
`timescale 1ns / 1ps

module date_day_number_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   input  wire logic [adtdn_pkg::TDATA_IN_W-1:0]    req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic [adtdn_pkg::TDATA_OUT_W-1:0]   rsp_tdata,
   output int                                       mismatches,
   output int                                       outstanding,
   output int                                       dates_taken,
   output int                                       dates_valid
);

   logic [adtdn_pkg::TDATA_OUT_W-1:0] pending_day_numbers [$];

   // Day number of one YYYYMMDD date, bytes weighted as code minus '0'.
   function automatic logic [adtdn_pkg::DAYNUM_W-1:0] day_number_of(
      input logic [adtdn_pkg::TDATA_IN_W-1:0] date_bytes);
      int digit [8];
      int year;
      int month;
      int day;
      int prev;
      int total;
      int month_base;
      bit leap;
      for (int i = 0; i < 8; i++) begin
         digit[i] = int'(date_bytes[8*i +: 8]) - adtdn_pkg::ASCII_ZERO;
      end
      year  = digit[0] * 1000 + digit[1] * 100 + digit[2] * 10 + digit[3];
      month = digit[4] * 10 + digit[5];
      day   = digit[6] * 10 + digit[7];
      if (day < 1 || day > adtdn_pkg::DAY_MAX || month < 1 || month > adtdn_pkg::MONTH_MAX ||
          year < adtdn_pkg::YEAR_MIN || year > adtdn_pkg::YEAR_MAX) begin
         return '0;
      end
      case (month)
         1:       month_base = 0;
         2:       month_base = 31;
         3:       month_base = 59;
         4:       month_base = 90;
         5:       month_base = 120;
         6:       month_base = 151;
         7:       month_base = 181;
         8:       month_base = 212;
         9:       month_base = 243;
         10:      month_base = 273;
         11:      month_base = 304;
         default: month_base = 334;
      endcase
      total = day + month_base;
      leap = (year % 400 == 0) || (year % 100 != 0 && year % 4 == 0);
      if (month > 2 && leap) begin
         total = total + 1;
      end
      prev = year - 1;
      total = total + prev * adtdn_pkg::DAYS_PER_YEAR + prev / 4 - prev / 100 + prev / 400;
      return total[adtdn_pkg::DAYNUM_W-1:0];
   endfunction

   initial begin
      mismatches  = 0;
      outstanding = 0;
      dates_taken = 0;
      dates_valid = 0;
   end

   always @(posedge clock) begin
      logic [adtdn_pkg::TDATA_OUT_W-1:0] want;
      logic [adtdn_pkg::DAYNUM_W-1:0]    predicted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_day_numbers.size() == 0) begin
               $display("%0t: unexpected day number item %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_day_numbers.pop_front();
               // pad bits above the day number must read zero too
               if (rsp_tdata !== want) begin
                  $display("%0t: day number expected %h actual %h", $time, want, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predicted = day_number_of(req_tdata);
            pending_day_numbers.push_back(
               {{(adtdn_pkg::TDATA_OUT_W-adtdn_pkg::DAYNUM_W){1'b0}}, predicted});
            dates_taken++;
            if (predicted != 0) begin
               dates_valid++;
            end
         end
         outstanding = pending_day_numbers.size();
      end
   end

endmodule

[tb/tb.sv]
// Top of the date converter testbench: clock, reset, date stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_DATES = 1200;
   localparam int QUIET_TAIL   = 150;   // last random dates go without idling
   localparam int PAUSE_AT     = 400;   // sender drains the block here

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [adtdn_pkg::TDATA_IN_W-1:0]    req_tdata;    // 8 ASCII bytes, thousands of year lowest
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [adtdn_pkg::TDATA_OUT_W-1:0]   rsp_tdata;    // [21:0] day_number, [23:22] zero
   logic                                quiet;        // no idling on either side when set

   int mismatches;
   int outstanding;
   int dates_taken;
   int dates_valid;

   ascii_date_to_day_number DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   date_day_number_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .dates_taken (dates_taken),
      .dates_valid (dates_valid)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hang guard: ~1230 dates fit far inside this time limit.
   initial begin
      #5_000_000;
      $display("ascii_date_to_day_number: mismatch");
      $finish;
   end

   // Eight-character date string to the bus layout (first character lowest).
   function automatic logic [adtdn_pkg::TDATA_IN_W-1:0] pack_text(input string text);
      logic [adtdn_pkg::TDATA_IN_W-1:0] packed_bytes;
      for (int i = 0; i < 8; i++) begin
         packed_bytes[8*i +: 8] = text.getc(i);
      end
      return packed_bytes;
   endfunction

   // Numeric year/month/day to ASCII digits; month and day take two digits.
   function automatic logic [adtdn_pkg::TDATA_IN_W-1:0] digits_of(input int year,
                                                                  input int month,
                                                                  input int day);
      logic [adtdn_pkg::TDATA_IN_W-1:0] packed_bytes;
      packed_bytes[7:0]   = 8'(adtdn_pkg::ASCII_ZERO + (year / 1000) % 10);
      packed_bytes[15:8]  = 8'(adtdn_pkg::ASCII_ZERO + (year / 100) % 10);
      packed_bytes[23:16] = 8'(adtdn_pkg::ASCII_ZERO + (year / 10) % 10);
      packed_bytes[31:24] = 8'(adtdn_pkg::ASCII_ZERO + year % 10);
      packed_bytes[39:32] = 8'(adtdn_pkg::ASCII_ZERO + (month / 10) % 10);
      packed_bytes[47:40] = 8'(adtdn_pkg::ASCII_ZERO + month % 10);
      packed_bytes[55:48] = 8'(adtdn_pkg::ASCII_ZERO + (day / 10) % 10);
      packed_bytes[63:56] = 8'(adtdn_pkg::ASCII_ZERO + day % 10);
      return packed_bytes;
   endfunction

   // Hold a date on the bus until it is taken; valid stays high afterwards.
   task automatic send_date(input logic [adtdn_pkg::TDATA_IN_W-1:0] date_bytes);
      req_tvalid <= 1'b1;
      req_tdata  <= date_bytes;
      do @(posedge clock); while (!req_tready);
   endtask

   // Random sender gap, skipped in the quiet tail.
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Random date shaped toward the interesting regions.
   function automatic logic [adtdn_pkg::TDATA_IN_W-1:0] random_date();
      logic [adtdn_pkg::TDATA_IN_W-1:0] date_bytes;
      int pick;
      int year;
      int month;
      int day;
      pick = $urandom_range(0, 99);
      year = ($urandom_range(0, 3) == 0) ? $urandom_range(1900, 2100)
                                         : $urandom_range(1900, 9999);
      month = $urandom_range(1, 12);
      day   = $urandom_range(1, 31);
      if (pick < 65) begin
         // well-formed dates, leap rules hit via the 1900..2100 bias
         date_bytes = digits_of(year, month, day);
      end else if (pick < 80) begin
         // around the range limits
         case ($urandom_range(0, 4))
            0: year = 1899;
            1: year = 1900;
            2: year = 9999;
            3: year = $urandom_range(0, 9999);
            default: ;
         endcase
         case ($urandom_range(0, 4))
            0: month = 0;
            1: month = 13;
            2: month = 12;
            3: month = $urandom_range(0, 99);
            default: ;
         endcase
         case ($urandom_range(0, 4))
            0: day = 0;
            1: day = 32;
            2: day = 31;
            3: day = $urandom_range(0, 99);
            default: ;
         endcase
         date_bytes = digits_of(year, month, day);
      end else if (pick < 90) begin
         // one character that is probably not a digit
         date_bytes = digits_of(year, month, day);
         date_bytes[8*$urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 255));
      end else if (pick < 95) begin
         // characters just around '0'..'9', weights can go negative or past 9
         for (int i = 0; i < 8; i++) begin
            date_bytes[8*i +: 8] = 8'($urandom_range(adtdn_pkg::ASCII_ZERO - 3,
                                                     adtdn_pkg::ASCII_ZERO + 12));
         end
      end else begin
         date_bytes = {$urandom, $urandom};
      end
      return date_bytes;
   endfunction

   // Result side: stall bursts of random length, ready stretches between.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      string directed_dates [$];
      int    drain_cycles;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      quiet      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: range limits on each field, leap rules, day past month end,
      // non-digit characters that still land in range, all-zero and all-one bytes.
      directed_dates = '{
         "19000101", "99991231", "19000100", "19000132", "19001301",
         "19000001", "18991231", "20000301", "19000301", "20040301",
         "21000301", "20000229", "19990231", "20241231", "16000101",
         "1:000101", "2/991231", "20230:01", "20231/01", "2023010:",
         "00000000", "99999999", "2024:001", "1999123/"
      };
      foreach (directed_dates[i]) begin
         send_date(pack_text(directed_dates[i]));
      end
      send_date('0);
      send_date('1);

      for (int n = 0; n < RANDOM_DATES; n++) begin
         if (n == PAUSE_AT) begin
            // let the block drain completely before going on; the count is
            // read between edges so that it includes the latest accepts
            req_tvalid <= 1'b0;
            do @(negedge clock); while (outstanding != 0);
            @(posedge clock);
         end
         if (n == RANDOM_DATES - QUIET_TAIL) begin
            quiet <= 1'b1;
         end
         maybe_idle();
         send_date(random_date());
      end
      req_tvalid <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      // wait on past the last expected result to catch stray items
      drain_cycles = 12;
      repeat (drain_cycles) @(posedge clock);

      $display("Converted %0d dates (%0d in range, %0d rejected) under random gaps and stalls.",
               dates_taken, dates_valid, dates_taken - dates_valid);
      if (mismatches == 0) begin
         $display("ascii_date_to_day_number: match");
      end else begin
         $display("ascii_date_to_day_number: mismatch");
      end
      $finish;
   end

endmodule

[ascii_date_to_day_number.f]
rtl/core/adtdn_pkg.sv
rtl/core/adtdn_front.sv
rtl/core/adtdn_queue.sv
rtl/core/adtdn_back.sv
rtl/core/ascii_date_to_day_number.sv
tb/date_day_number_checker.sv
tb/tb.sv
